// ===== design/fbcs_pkg.sv =====
// ----------------------------------------------------------------------------
// fbcs_pkg
// Types, constants and codes shared by the channel scheduler modules.
// ----------------------------------------------------------------------------
package fbcs_pkg;

  localparam int MaxTasksDefault = 16;
  localparam logic [31:0] BudgetReset = 32'd1000000;
  localparam logic [19:0] OneSecondUs = 20'd1000000;
  localparam logic [23:0] DefaultAvgUs = 24'd10000;
  localparam logic [47:0] Mask48 = 48'hFFFF_FFFF_FFFF;
  localparam int QueueDepth = 2;

  typedef enum logic [2:0] {
    CMD_ADD       = 3'd0,
    CMD_UPDATE    = 3'd1,
    CMD_REMOVE    = 3'd2,
    CMD_ENABLE    = 3'd3,
    CMD_GATE      = 3'd4,
    CMD_REPORT    = 3'd5,
    CMD_REBALANCE = 3'd6,
    CMD_STATS     = 3'd7
  } cmd_t;

  localparam logic [1:0] STRAT_REALTIME = 2'd0;
  localparam logic [1:0] STRAT_POLLING  = 2'd1;
  localparam logic [1:0] STRAT_ONDEMAND = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  chan_id;
    logic [1:0]  strategy;
    logic [7:0]  req_fps;
    logic        enable_bit;
    logic [47:0] now_us;
    logic [23:0] inference_us;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  req_fps_out;
    logic [7:0]  effective_fps_out;
    logic        throttled;
    logic [31:0] inference_count;
    logic [23:0] avg_inference_us;
    logic [39:0] load_est_us;
    logic [6:0]  active_count;
  } out_item_t;

endpackage

// ===== design/fps_budget_channel_scheduler.sv =====
// ----------------------------------------------------------------------------
// fps_budget_channel_scheduler
// Commands that need a division, and rebalance, are paced by the shared
// 48-step divider.
// One item is executed at a time; busy is high while the queue is full.
// Reset clears the table valid bits and loads the budget with 1000000.
// The receiver cannot stall; each result strobes done for one cycle.
// ----------------------------------------------------------------------------
module fps_budget_channel_scheduler import fbcs_pkg::*; #(
  parameter int MaxTasks = MaxTasksDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        done,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic        q_valid;
  in_item_t    q_item;
  logic        q_pop;
  logic [31:0] budget;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= BudgetReset;
    end else if (cfg_valid) begin
      budget <= cfg_data;
    end
  end

  fbcs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .in_item (in_item),
    .busy    (busy),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  fbcs_back #(.MaxTasks(MaxTasks)) u_back (
    .clk          (clk),
    .rst          (rst),
    .budget       (budget),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .result_valid (done),
    .result       (out_item)
  );

endmodule

// ===== design/fbcs_divider.sv =====
// ----------------------------------------------------------------------------
// fbcs_divider
// Restoring radix-2 divider, one quotient bit per cycle, 48-bit operands.
// ----------------------------------------------------------------------------
module fbcs_divider import fbcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [47:0] divisor,
  output logic        done,
  output logic [47:0] quotient
);

  logic [47:0] rem;
  logic [47:0] quo;
  logic [47:0] dvs;
  logic [5:0]  cnt;
  logic        run;
  logic [48:0] trial;

  assign trial = {rem[46:0], quo[47]} - {1'b0, dvs} ;
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 6'd48;
        rem <= '0;
        quo <= dividend;
        dvs <= divisor;
      end else if (run) begin
        if (!trial[48] || rem[47]) begin
          rem <= trial[47:0];
          quo <= {quo[46:0], 1'b1};
        end else begin
          rem <= {rem[46:0], quo[47]};
          quo <= {quo[46:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/fbcs_front.sv =====
// ----------------------------------------------------------------------------
// fbcs_front
// Accepts command items and queues them for the execution engine.
// ----------------------------------------------------------------------------
module fbcs_front import fbcs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  in_item_t in_item,
  output logic     busy,
  output logic     q_valid,
  output in_item_t q_item,
  input  logic     q_pop
);

  localparam int PtrW = $clog2(QueueDepth);

  in_item_t           mem [QueueDepth];
  logic [PtrW-1:0]    wptr;
  logic [PtrW-1:0]    rptr;
  logic [PtrW:0]      fill;
  logic               push;

  assign busy = (fill == (PtrW+1)'(QueueDepth));
  assign push = start && !busy;
  assign q_valid = (fill != '0);
  assign q_item = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_item;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (q_pop) begin
        rptr <= rptr + 1'b1;
      end
      fill <= fill + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
    end
  end

endmodule

// ===== design/fbcs_back.sv =====
// ----------------------------------------------------------------------------
// fbcs_back
// Execution engine: channel table, gate, report, stats and rebalance walk.
// ----------------------------------------------------------------------------
module fbcs_back import fbcs_pkg::*; #(
  parameter int MaxTasks = MaxTasksDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] budget,
  input  logic        q_valid,
  input  in_item_t    q_item,
  output logic        q_pop,
  output logic        result_valid,
  output out_item_t   result
);

  localparam int IdxW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int CntW = $clog2(MaxTasks + 1);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_LOOK   = 10'b0000000010,
    S_EXEC   = 10'b0000000100,
    S_DIVW   = 10'b0000001000,
    S_SUM    = 10'b0000010000,
    S_PICK   = 10'b0000100000,
    S_GRANT  = 10'b0001000000,
    S_IVAL   = 10'b0010000000,
    S_CLEAR  = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  typedef enum logic [1:0] {
    USE_IVAL   = 2'd0,
    USE_AVG    = 2'd1,
    USE_FPS    = 2'd2,
    USE_DECIDE = 2'd3
  } div_use_t;

  state_t state;

  logic [MaxTasks-1:0] ev;
  logic [7:0]  e_ch   [MaxTasks];
  logic [1:0]  e_st   [MaxTasks];
  logic        e_en   [MaxTasks];
  logic [7:0]  e_tf   [MaxTasks];
  logic [7:0]  e_ef   [MaxTasks];
  logic        e_th   [MaxTasks];
  logic [19:0] e_iv   [MaxTasks];
  logic [47:0] e_lt   [MaxTasks];
  logic [31:0] e_cnt  [MaxTasks];
  logic [47:0] e_tot  [MaxTasks];
  logic [23:0] e_avg  [MaxTasks];

  in_item_t    cur;
  logic        hit;
  logic [IdxW-1:0] slot;
  logic        has_free;
  logic [IdxW-1:0] free_slot;
  out_item_t   res;

  logic        div_start;
  logic [47:0] div_a;
  logic [47:0] div_b;
  logic        div_done;
  logic [47:0] div_q;
  div_use_t    div_use;
  logic [IdxW-1:0] div_idx;

  logic [IdxW-1:0] walk;
  logic [47:0] est;
  logic [CntW-1:0] nact;
  logic        any;
  logic [MaxTasks-1:0] pending;
  logic [47:0] remaining;
  logic [31:0] need;
  logic [IdxW-1:0] pick;
  logic        pick_ok;
  logic [9:0]  pick_key;

  fbcs_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    hit = 1'b0;
    slot = '0;
    has_free = 1'b0;
    free_slot = '0;
    for (int i = MaxTasks - 1; i >= 0; i--) begin
      if (ev[i] && e_ch[i] == cur.chan_id) begin
        hit = 1'b1;
        slot = IdxW'(i);
      end
      if (!ev[i]) begin
        has_free = 1'b1;
        free_slot = IdxW'(i);
      end
    end
  end

  always_comb begin
    pick_ok = 1'b0;
    pick = '0;
    pick_key = '1;
    for (int i = 0; i < MaxTasks; i++) begin
      if (pending[i] && (!pick_ok ||
          {(e_st[i][1] ? STRAT_ONDEMAND : e_st[i]), e_ch[i]} < pick_key)) begin
        pick_ok = 1'b1;
        pick = IdxW'(i);
        pick_key = {(e_st[i][1] ? STRAT_ONDEMAND : e_st[i]), e_ch[i]};
      end
    end
  end

  logic [23:0] w_avg;
  logic [23:0] p_avg;
  logic [23:0] d_avg;
  logic [47:0] gate_iv;
  assign w_avg = (e_cnt[walk] != '0) ? e_avg[walk] : DefaultAvgUs;
  assign p_avg = (e_cnt[pick] != '0) ? e_avg[pick] : DefaultAvgUs;
  assign d_avg = (e_cnt[div_idx] != '0) ? e_avg[div_idx] : DefaultAvgUs;
  assign gate_iv = e_th[slot] ? {27'd0, e_iv[slot], 1'b0} : {28'd0, e_iv[slot]};

  assign q_pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ev <= '0;
      result_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      div_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          res <= '0;
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_DONE;
          unique case (cmd_t'(cur.command))
            CMD_ADD: begin
              if (!hit && has_free) begin
                ev[free_slot] <= 1'b1;
                e_ch[free_slot] <= cur.chan_id;
                e_st[free_slot] <= cur.strategy;
                e_en[free_slot] <= cur.enable_bit;
                e_tf[free_slot] <= cur.req_fps;
                e_ef[free_slot] <= cur.req_fps;
                e_th[free_slot] <= 1'b0;
                e_iv[free_slot] <= '0;
                e_lt[free_slot] <= cur.now_us;
                e_cnt[free_slot] <= '0;
                e_tot[free_slot] <= '0;
                e_avg[free_slot] <= '0;
                res.ok <= 1'b1;
                if (cur.req_fps != '0) begin
                  div_a <= {28'd0, OneSecondUs};
                  div_b <= {40'd0, cur.req_fps};
                  div_idx <= free_slot;
                  div_use <= USE_IVAL;
                  div_start <= 1'b1;
                  state <= S_DIVW;
                end
              end
            end
            CMD_UPDATE: begin
              if (hit) begin
                e_st[slot] <= cur.strategy;
                e_tf[slot] <= cur.req_fps;
                e_en[slot] <= cur.enable_bit;
                res.ok <= 1'b1;
                if (cur.req_fps != '0) begin
                  div_a <= {28'd0, OneSecondUs};
                  div_b <= {40'd0, cur.req_fps};
                  div_idx <= slot;
                  div_use <= USE_IVAL;
                  div_start <= 1'b1;
                  state <= S_DIVW;
                end
              end
            end
            CMD_REMOVE: begin
              if (hit) begin
                ev[slot] <= 1'b0;
                res.ok <= 1'b1;
              end
            end
            CMD_ENABLE: begin
              if (hit) begin
                e_en[slot] <= cur.enable_bit;
                res.ok <= 1'b1;
              end
            end
            CMD_GATE: begin
              if (hit && e_en[slot]) begin
                if (e_st[slot] == STRAT_REALTIME) begin
                  res.ok <= 1'b1;
                end else if (e_st[slot] == STRAT_POLLING) begin
                  if (cur.now_us >= e_lt[slot] && cur.now_us - e_lt[slot] >= gate_iv) begin
                    e_lt[slot] <= cur.now_us;
                    res.ok <= 1'b1;
                  end
                end
              end
            end
            CMD_REPORT: begin
              if (hit) begin
                logic [48:0] tsum;
                tsum = {1'b0, e_tot[slot]} + 49'(cur.inference_us);
                if (e_cnt[slot] != '1) begin
                  e_cnt[slot] <= e_cnt[slot] + 32'd1;
                end
                e_tot[slot] <= tsum[48] ? Mask48 : tsum[47:0];
                res.ok <= 1'b1;
                div_a <= tsum[48] ? Mask48 : tsum[47:0];
                div_b <= (e_cnt[slot] != '1) ? 48'(e_cnt[slot]) + 48'd1 : 48'(e_cnt[slot]);
                div_idx <= slot;
                div_use <= USE_AVG;
                div_start <= 1'b1;
                state <= S_DIVW;
              end
            end
            CMD_REBALANCE: begin
              walk <= '0;
              est <= '0;
              nact <= '0;
              any <= 1'b0;
              pending <= '0;
              state <= S_SUM;
            end
            CMD_STATS: begin
              if (hit) begin
                res.ok <= 1'b1;
                res.req_fps_out <= e_tf[slot];
                res.effective_fps_out <= e_ef[slot];
                res.throttled <= e_th[slot];
                res.inference_count <= e_cnt[slot];
                res.avg_inference_us <= e_avg[slot];
              end
            end
            default: ;
          endcase
        end
        S_DIVW: begin
          if (div_done) begin
            unique case (div_use)
              USE_IVAL: e_iv[div_idx] <= div_q[19:0];
              USE_AVG: e_avg[div_idx] <= div_q[23:0];
              default: begin
                e_th[div_idx] <= 1'b1;
                e_ef[div_idx] <= (div_q == '0) ? 8'd1 :
                                 (div_q > 48'd255) ? 8'd255 : div_q[7:0];
              end
            endcase
            if (div_use == USE_FPS) begin
              state <= S_IVAL;
            end else if (cur.command == CMD_REBALANCE && res.ok) begin
              state <= S_GRANT;
            end else if (cur.command == CMD_REBALANCE &&
                         div_idx != IdxW'(MaxTasks - 1)) begin
              state <= S_CLEAR;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SUM: begin
          if (ev[walk]) begin
            any <= 1'b1;
            if (e_en[walk]) begin
              est <= est + 48'(w_avg) * 48'(e_tf[walk]);
              nact <= nact + 1'b1;
              pending[walk] <= 1'b1;
            end
          end
          if (walk == IdxW'(MaxTasks - 1)) begin
            state <= S_PICK;
          end else begin
            walk <= walk + 1'b1;
          end
        end
        S_PICK: begin
          if (!any) begin
            state <= S_DONE;
          end else begin
            res.load_est_us <= est[39:0];
            res.active_count <= 7'(nact);
            if (est > 48'(budget)) begin
              res.ok <= 1'b1;
              remaining <= 48'(budget);
              state <= S_GRANT;
            end else begin
              walk <= '0;
              state <= S_CLEAR;
            end
          end
        end
        S_GRANT: begin
          if (!pick_ok) begin
            state <= S_DONE;
          end else begin
            need <= 32'(p_avg) * 32'(e_tf[pick]);
            div_idx <= pick;
            pending[pick] <= 1'b0;
            state <= S_IVAL;
            div_use <= USE_DECIDE;
          end
        end
        S_IVAL: begin
          if (div_use == USE_DECIDE) begin
            if (remaining >= 48'(need)) begin
              e_th[div_idx] <= 1'b0;
              e_ef[div_idx] <= e_tf[div_idx];
              remaining <= remaining - 48'(need);
              div_use <= USE_IVAL;
            end else if (remaining != '0 && d_avg != '0) begin
              div_a <= remaining;
              div_b <= 48'(d_avg);
              remaining <= '0;
              div_use <= USE_FPS;
              div_start <= 1'b1;
              state <= S_DIVW;
            end else begin
              e_th[div_idx] <= 1'b1;
              e_ef[div_idx] <= 8'd1;
              div_use <= USE_IVAL;
            end
          end else begin
            if (e_ef[div_idx] != '0) begin
              div_a <= {28'd0, OneSecondUs};
              div_b <= {40'd0, e_ef[div_idx]};
              div_use <= USE_IVAL;
              div_start <= 1'b1;
              state <= S_DIVW;
            end else begin
              state <= S_GRANT;
            end
          end
        end
        S_CLEAR: begin
          if (ev[walk]) begin
            e_th[walk] <= 1'b0;
            e_ef[walk] <= e_tf[walk];
          end
          div_idx <= walk;
          if (ev[walk] && e_tf[walk] != '0) begin
            div_a <= {28'd0, OneSecondUs};
            div_b <= {40'd0, e_tf[walk]};
            div_use <= USE_IVAL;
            div_start <= 1'b1;
            state <= S_DIVW;
          end
          if (walk == IdxW'(MaxTasks - 1)) begin
            if (!(ev[walk] && e_tf[walk] != '0)) begin
              state <= S_DONE;
            end
          end else begin
            walk <= walk + 1'b1;
          end
        end
        S_DONE: begin
          result_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result = res;

endmodule
